// File: rtl/ttrml_pkg.sv
// Package with shared types and constants of the ranked move list.
package ttrml_pkg;
    localparam int LIST_SLOTS = 10;
    localparam int IDX_W = 4;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CHECK  = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic [63:0] wlo;
        logic [63:0] whi;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] s3;
        logic [31:0] extra;
        logic [7:0]  row;
        logic [7:0]  col;
    } rec_t;

    typedef struct packed {
        logic [1:0]  op;
        rec_t        rec;
        logic        eligible;
        logic [3:0]  slot;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  entry_count;
        rec_t        rec;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture request, clear scan index
        logic scan_step;   // compare entry at index and advance
        logic commit;      // perform the update and build the response
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } sts_t;

    function automatic logic rank_ge(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) >= $signed(b);
    endfunction

    function automatic logic same_word(input rec_t a, input rec_t b);
        logic [127:0] x;
        logic [127:0] y;
        logic         res;
        logic         done;
        x = {a.wlo, a.whi};
        y = {b.wlo, b.whi};
        res = 1'b1;
        done = 1'b0;
        for (int i = 0; i < 16; i++) begin
            if (!done) begin
                if (x[127 - 8*i -: 8] != y[127 - 8*i -: 8]) begin
                    res = 1'b0;
                    done = 1'b1;
                end else if (x[127 - 8*i -: 8] == 8'd0) begin
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction
endpackage

// File: rtl/ttrml_if.sv
// Valid/ready channel interface carrying one payload.
interface ttrml_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ttrml_ctrl.sv
// Controller state machine sequencing load, scan and commit of each request.
module ttrml_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output ttrml_pkg::cmd_t cmd,
    input  ttrml_pkg::sts_t sts
);
    import ttrml_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                    state_next = S_COMMIT;
                else
                    cmd.scan_step = 1'b1;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

// File: rtl/ttrml_dp.sv
// Datapath holding the sorted list, the scan index and the response register.
module ttrml_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  ttrml_pkg::cmd_t cmd,
    output ttrml_pkg::sts_t sts,
    input  ttrml_pkg::req_t req,
    output ttrml_pkg::rsp_t rsp
);
    import ttrml_pkg::*;

    rec_t                 list_reg [LIST_SLOTS];
    logic [IDX_W-1:0]     count_reg;
    logic [31:0]          cutoff_reg;
    req_t                 req_reg;
    logic [31:0]          rank_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     pos_reg;
    logic                 found_reg;
    logic                 stop_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;

    rec_t                 cur;
    logic [31:0]          cur_rank;
    logic                 at_end;
    logic                 ins_reject;
    logic                 chk_reject;
    logic [IDX_W-1:0]     new_count;
    logic [31:0]          last_rank;

    assign cur = list_reg[idx_reg];
    assign cur_rank = cur.s1 + cur.s2 + cur.s3;
    assign at_end = (idx_reg >= count_reg) || stop_reg;
    assign sts.scan_done = at_end;
    assign rsp = rsp_reg;

    assign ins_reject = !req_reg.eligible ||
        ((count_reg == IDX_W'(LIST_SLOTS)) &&
         (!rank_ge(rank_reg, cutoff_reg) || rank_reg == cutoff_reg));
    assign chk_reject = found_reg && rank_ge(list_reg[pos_reg].s1 +
        list_reg[pos_reg].s2 + list_reg[pos_reg].s3, rank_reg);
    assign new_count = (count_reg == IDX_W'(LIST_SLOTS)) ? count_reg :
        count_reg + 1'b1;

    always_comb
    begin
        last_rank = list_reg[LIST_SLOTS-1].s1 + list_reg[LIST_SLOTS-1].s2 +
            list_reg[LIST_SLOTS-1].s3;
        if (pos_reg == IDX_W'(LIST_SLOTS-1))
            last_rank = req_reg.rec.s1 + req_reg.rec.s2 + req_reg.rec.s3;
        else if (pos_reg < IDX_W'(LIST_SLOTS-1) && new_count == IDX_W'(LIST_SLOTS))
            last_rank = list_reg[LIST_SLOTS-2].s1 + list_reg[LIST_SLOTS-2].s2 +
                list_reg[LIST_SLOTS-2].s3;
    end

    always_comb
    begin
        rsp_next = '0;
        rsp_next.entry_count = count_reg;
        case (req_reg.op)
            OP_INSERT:
            begin
                rsp_next.accepted = !ins_reject;
                if (!ins_reject)
                    rsp_next.entry_count = new_count;
            end
            OP_CHECK:
            begin
                rsp_next.accepted = !chk_reject;
                if (found_reg && !chk_reject)
                    rsp_next.entry_count = count_reg - 1'b1;
            end
            OP_READ:
            begin
                if (req_reg.slot < count_reg)
                begin
                    rsp_next.accepted = 1'b1;
                    rsp_next.rec = list_reg[req_reg.slot];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            rank_reg <= req.rec.s1 + req.rec.s2 + req.rec.s3;
            pos_reg <= '0;
        end else if (cmd.scan_step)
        begin
            if (req_reg.op == OP_CHECK)
            begin
                if (same_word(cur, req_reg.rec))
                    pos_reg <= idx_reg;
            end else if (rank_ge(cur_rank, rank_reg))
                pos_reg <= idx_reg + 1'b1;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
            case (req_reg.op)
                OP_INSERT:
                begin
                    if (!ins_reject)
                    begin
                        for (int i = 1; i < LIST_SLOTS; i++)
                            if (IDX_W'(i) > pos_reg && IDX_W'(i) < new_count)
                                list_reg[i] <= list_reg[i-1];
                        if (pos_reg < IDX_W'(LIST_SLOTS))
                            list_reg[pos_reg] <= req_reg.rec;
                    end
                end
                OP_CHECK:
                begin
                    if (found_reg && !chk_reject)
                    begin
                        for (int i = 0; i < LIST_SLOTS-1; i++)
                            if (IDX_W'(i) >= pos_reg && IDX_W'(i) < count_reg - 1'b1)
                                list_reg[i] <= list_reg[i+1];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cutoff_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            stop_reg <= 1'b0;
        end else if (cmd.load)
        begin
            idx_reg <= '0;
            found_reg <= 1'b0;
            stop_reg <= (req.op != OP_INSERT) && (req.op != OP_CHECK);
        end else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (req_reg.op == OP_CHECK)
            begin
                if (same_word(cur, req_reg.rec))
                begin
                    found_reg <= 1'b1;
                    stop_reg <= 1'b1;
                end
            end else if (!rank_ge(cur_rank, rank_reg))
                stop_reg <= 1'b1;
        end else if (cmd.commit)
        begin
            if (req_reg.op == OP_INSERT && !ins_reject)
            begin
                count_reg <= new_count;
                cutoff_reg <= last_rank;
            end else if (req_reg.op == OP_CHECK && found_reg && !chk_reject)
                count_reg <= count_reg - 1'b1;
        end
    end
endmodule

// File: rtl/top_ten_ranked_move_list_unit.sv
// Top level of the ranked move list: controller, datapath and channel ports.
//   channel  direction  payload
//   req      in         op, move record, eligible, slot
//   rsp      out        accepted, entry_count, read record
// A response is valid after its request is taken, once the scan over stored
// entries and the commit are done; the controller then returns to idle to take
// the next request. The scan steps through stored entries with a single compare.
// Reset clears the entry count and cutoff; entries are undefined until written.
// The response waits in its register while rsp.ready is low; no new request is taken then.
module top_ten_ranked_move_list_unit (
    input  logic    clk,
    input  logic    rst_n,
    ttrml_if.sink   req,
    ttrml_if.source rsp
);
    import ttrml_pkg::*;

    cmd_t cmd;
    sts_t sts;
    req_t req_data;
    rsp_t rsp_data;

    assign req_data = req.data;
    assign rsp.data = rsp_data;

    ttrml_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ttrml_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req_data),
        .rsp   (rsp_data)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request taken while response pending");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.data.entry_count <= 4'd10)
        else $error("entry count out of range");
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("conflicting datapath commands");
endmodule
